// ----- rtl/qpr_pkg.sv -----
package qpr_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  // operation codes
  localparam logic OP_PRODUCT = 1'b0;
  localparam logic OP_ROTATE  = 1'b1;

  // component order inside a quaternion array
  localparam int IX = 0;
  localparam int IY = 1;
  localparam int IZ = 2;
  localparam int IW = 3;
  localparam int NCOMP = 4;

endpackage

// ----- rtl/qpr_hamilton.sv -----
module qpr_hamilton
  import qpr_pkg::*;
#(
  parameter int AW   = DATA_WIDTH_DEF,
  parameter int BW   = DATA_WIDTH_DEF,
  parameter int OW   = DATA_WIDTH_DEF,
  parameter int FRAC = FRAC_BITS_DEF,
  parameter int SW   = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [AW-1:0] a_i [NCOMP],
  input  logic signed [BW-1:0] b_i [NCOMP],
  input  logic        [SW-1:0] side_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic signed [OW-1:0] r_o [NCOMP],
  output logic        [SW-1:0] side_o
);

  localparam int PW   = AW + BW;
  localparam int SUMW = PW + 3;

  localparam logic signed [SUMW-1:0] HALF =
    {{(SUMW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
  localparam logic signed [SUMW-1:0] SAT_HI =
    {{(SUMW-OW+1){1'b0}}, {(OW-1){1'b1}}};
  localparam logic signed [SUMW-1:0] SAT_LO = ~SAT_HI;

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  // products: [component][term]
  logic signed [PW-1:0]   p_nxt [NCOMP][4];
  logic signed [PW-1:0]   p_r   [NCOMP][4];
  logic        [SW-1:0]   side1_r, side2_r, side3_r;
  logic signed [SUMW-1:0] s_nxt [NCOMP];
  logic signed [SUMW-1:0] s_r   [NCOMP];
  logic signed [OW-1:0]   r_nxt [NCOMP];
  logic signed [OW-1:0]   r_r   [NCOMP];

  assign en3     = !v3_r || ready_i;
  assign en2     = !v2_r || en3;
  assign en1     = !v1_r || en2;
  assign ready_o = en1;

  function automatic logic signed [PW-1:0] mul(input logic signed [AW-1:0] x,
                                               input logic signed [BW-1:0] y);
    logic signed [PW-1:0] xe;
    logic signed [PW-1:0] ye;
    xe = {{BW{x[AW-1]}}, x};
    ye = {{AW{y[BW-1]}}, y};
    return PW'(xe * ye);
  endfunction

  // term order: the first term is added, the last is subtracted for x, y, z;
  // for w only the first is added
  always_comb begin
    p_nxt[IX][0] = mul(a_i[IX], b_i[IW]);
    p_nxt[IX][1] = mul(a_i[IW], b_i[IX]);
    p_nxt[IX][2] = mul(a_i[IY], b_i[IZ]);
    p_nxt[IX][3] = mul(a_i[IZ], b_i[IY]);

    p_nxt[IY][0] = mul(a_i[IY], b_i[IW]);
    p_nxt[IY][1] = mul(a_i[IW], b_i[IY]);
    p_nxt[IY][2] = mul(a_i[IZ], b_i[IX]);
    p_nxt[IY][3] = mul(a_i[IX], b_i[IZ]);

    p_nxt[IZ][0] = mul(a_i[IZ], b_i[IW]);
    p_nxt[IZ][1] = mul(a_i[IW], b_i[IZ]);
    p_nxt[IZ][2] = mul(a_i[IX], b_i[IY]);
    p_nxt[IZ][3] = mul(a_i[IY], b_i[IX]);

    p_nxt[IW][0] = mul(a_i[IW], b_i[IW]);
    p_nxt[IW][1] = mul(a_i[IX], b_i[IX]);
    p_nxt[IW][2] = mul(a_i[IY], b_i[IY]);
    p_nxt[IW][3] = mul(a_i[IZ], b_i[IZ]);
  end

  // exact sum plus half an output lsb
  always_comb begin
    for (int c = 0; c < NCOMP - 1; c++) begin
      s_nxt[c] = SUMW'(p_r[c][0]) + SUMW'(p_r[c][1]) + SUMW'(p_r[c][2])
               - SUMW'(p_r[c][3]) + HALF;
    end
    s_nxt[IW] = SUMW'(p_r[IW][0]) - SUMW'(p_r[IW][1]) - SUMW'(p_r[IW][2])
              - SUMW'(p_r[IW][3]) + HALF;
  end

  // floor shift then saturate
  always_comb begin
    logic signed [SUMW-1:0] rnd;
    for (int c = 0; c < NCOMP; c++) begin
      rnd = s_r[c] >>> FRAC;
      if (rnd > SAT_HI) begin
        r_nxt[c] = SAT_HI[OW-1:0];
      end else if (rnd < SAT_LO) begin
        r_nxt[c] = SAT_LO[OW-1:0];
      end else begin
        r_nxt[c] = rnd[OW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= valid_i;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      p_r     <= p_nxt;
      side1_r <= side_i;
    end
    if (en2) begin
      s_r     <= s_nxt;
      side2_r <= side1_r;
    end
    if (en3) begin
      r_r     <= r_nxt;
      side3_r <= side2_r;
    end
  end

  assign valid_o = v3_r;
  assign r_o     = r_r;
  assign side_o  = side3_r;

endmodule

// ----- rtl/quaternion_product_rotate.sv -----
// Quaternion product and vector rotation in signed fixed point (Q1.14 in 16 bits
// by default). op = 0 returns the Hamilton product a*b; op = 1 rotates (a_x, a_y,
// a_z) by quaternion b as b*(a,0)*conj(b) and returns the vector with r_w = 0.
// Every component is rounded half up and saturated, the rotation also after its
// first product. The block accepts one beat per clock while in_stall is low; a
// beat passes through two Hamilton passes of three stages each (sixteen parallel
// multipliers, four-term sum, round and saturate), then the output register. The
// multiplier stage of each pass takes a new operand set every cycle unless that
// pass is held by back-pressure. Back-pressure on out_stall holds beats in
// place; empty stages keep filling, so in_stall rises only when every stage holds
// a beat.
module quaternion_product_rotate
  import qpr_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic signed [DATA_WIDTH-1:0] in_a_x,
  input  logic signed [DATA_WIDTH-1:0] in_a_y,
  input  logic signed [DATA_WIDTH-1:0] in_a_z,
  input  logic signed [DATA_WIDTH-1:0] in_a_w,
  input  logic signed [DATA_WIDTH-1:0] in_b_x,
  input  logic signed [DATA_WIDTH-1:0] in_b_y,
  input  logic signed [DATA_WIDTH-1:0] in_b_z,
  input  logic signed [DATA_WIDTH-1:0] in_b_w,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_r_x,
  output logic signed [DATA_WIDTH-1:0] out_r_y,
  output logic signed [DATA_WIDTH-1:0] out_r_z,
  output logic signed [DATA_WIDTH-1:0] out_r_w
);

  localparam int W  = DATA_WIDTH;
  localparam int SW = 1 + NCOMP * W;

  logic signed [W-1:0] a1 [NCOMP];
  logic signed [W-1:0] b1 [NCOMP];
  logic        [SW-1:0] side1_in, side1_out;
  logic signed [W-1:0] r1 [NCOMP];
  logic                v1, rdy1, rdy2;

  logic signed [W-1:0] a2 [NCOMP];
  logic signed [W:0]   b2 [NCOMP];
  logic        [SW-1:0] side2_in, side2_out;
  logic signed [W-1:0] r2 [NCOMP];
  logic                v2;

  logic                op1, op2;
  logic signed [W-1:0] bq [NCOMP];
  logic signed [W-1:0] rq [NCOMP];

  logic                out_valid_r;
  logic                out_en;
  logic signed [W-1:0] out_x_r, out_y_r, out_z_r, out_w_r;
  logic signed [W-1:0] res_nxt [NCOMP];

  // first pass: product a*b, or b*(a,0) for rotation
  always_comb begin
    if (in_op == OP_ROTATE) begin
      a1[IX] = in_b_x;
      a1[IY] = in_b_y;
      a1[IZ] = in_b_z;
      a1[IW] = in_b_w;
      b1[IX] = in_a_x;
      b1[IY] = in_a_y;
      b1[IZ] = in_a_z;
      b1[IW] = '0;
    end else begin
      a1[IX] = in_a_x;
      a1[IY] = in_a_y;
      a1[IZ] = in_a_z;
      a1[IW] = in_a_w;
      b1[IX] = in_b_x;
      b1[IY] = in_b_y;
      b1[IZ] = in_b_z;
      b1[IW] = in_b_w;
    end
  end

  assign side1_in = {in_op, in_b_w, in_b_z, in_b_y, in_b_x};

  qpr_hamilton #(
    .AW(W), .BW(W), .OW(W), .FRAC(FRAC_BITS), .SW(SW)
  ) u_pass1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_valid),
    .ready_o (rdy1),
    .a_i     (a1),
    .b_i     (b1),
    .side_i  (side1_in),
    .valid_o (v1),
    .ready_i (rdy2),
    .r_o     (r1),
    .side_o  (side1_out)
  );

  assign in_stall = !rdy1;

  // second pass: t * conj(b), conj formed one bit wider so it stays exact
  always_comb begin
    op1 = side1_out[SW-1];
    for (int c = 0; c < NCOMP; c++) begin
      bq[c] = side1_out[c*W +: W];
      a2[c] = r1[c];
    end
    b2[IX] = -{bq[IX][W-1], bq[IX]};
    b2[IY] = -{bq[IY][W-1], bq[IY]};
    b2[IZ] = -{bq[IZ][W-1], bq[IZ]};
    b2[IW] = {bq[IW][W-1], bq[IW]};
  end

  assign side2_in = {op1, r1[IW], r1[IZ], r1[IY], r1[IX]};

  qpr_hamilton #(
    .AW(W), .BW(W + 1), .OW(W), .FRAC(FRAC_BITS), .SW(SW)
  ) u_pass2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (v1),
    .ready_o (rdy2),
    .a_i     (a2),
    .b_i     (b2),
    .side_i  (side2_in),
    .valid_o (v2),
    .ready_i (out_en),
    .r_o     (r2),
    .side_o  (side2_out)
  );

  // product beats take the first-pass result, carried through the second pass as side data
  always_comb begin
    op2 = side2_out[SW-1];
    for (int c = 0; c < NCOMP; c++) begin
      rq[c] = side2_out[c*W +: W];
    end
    if (op2 == OP_ROTATE) begin
      res_nxt[IX] = r2[IX];
      res_nxt[IY] = r2[IY];
      res_nxt[IZ] = r2[IZ];
      res_nxt[IW] = '0;
    end else begin
      res_nxt = rq;
    end
  end

  assign out_en = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_x_r <= res_nxt[IX];
      out_y_r <= res_nxt[IY];
      out_z_r <= res_nxt[IZ];
      out_w_r <= res_nxt[IW];
    end
  end

  assign out_valid = out_valid_r;
  assign out_r_x   = out_x_r;
  assign out_r_y   = out_y_r;
  assign out_r_z   = out_z_r;
  assign out_r_w   = out_w_r;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import qpr_pkg::*;

  localparam int DW = DATA_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int ONE_Q = 1 << FB;
  localparam longint HALF_LSB = longint'(1) << (FB - 1);
  localparam longint WORD_MAX = (longint'(1) << (DW - 1)) - 1;
  localparam longint WORD_MIN = -WORD_MAX - 1;
  localparam int RANDOM_BEATS = 940;
  localparam int QUIET_BEATS = 100;
  localparam int STUCK_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 16;

  typedef logic signed [DW-1:0] word_t;
  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
    word_t w;
  } quat_word_t;
  typedef struct {
    longint x;
    longint y;
    longint z;
    longint w;
  } quat_exact_t;

  class quat_checker;
    quat_word_t expected_results[$];
    int products;
    int rotations;
    int checked;
    int mismatches;

    function longint round_sat(longint acc);
      longint r;
      // add half an lsb, then floor: ties go toward plus infinity
      r = (acc + HALF_LSB) >>> FB;
      if (r > WORD_MAX) r = WORD_MAX;
      else if (r < WORD_MIN) r = WORD_MIN;
      return r;
    endfunction

    function quat_exact_t hamilton(quat_exact_t p, quat_exact_t q);
      quat_exact_t r;
      r.x = round_sat(p.x * q.w + q.x * p.w + p.y * q.z - p.z * q.y);
      r.y = round_sat(p.y * q.w + q.y * p.w + p.z * q.x - p.x * q.z);
      r.z = round_sat(p.z * q.w + q.z * p.w + p.x * q.y - p.y * q.x);
      r.w = round_sat(p.w * q.w - p.x * q.x - p.y * q.y - p.z * q.z);
      return r;
    endfunction

    function quat_exact_t widen(quat_word_t q);
      quat_exact_t r;
      r.x = longint'($signed(q.x));
      r.y = longint'($signed(q.y));
      r.z = longint'($signed(q.z));
      r.w = longint'($signed(q.w));
      return r;
    endfunction

    function quat_word_t predict_result(logic op, quat_word_t a, quat_word_t b);
      quat_exact_t qa;
      quat_exact_t qb;
      quat_exact_t t;
      quat_exact_t conj_b;
      quat_exact_t r;
      quat_word_t res;
      qa = widen(a);
      qb = widen(b);
      if (op == OP_PRODUCT) begin
        r = hamilton(qa, qb);
      end else begin
        qa.w = 0;
        t = hamilton(qb, qa);
        // conjugate kept exact, one bit wider than a word
        conj_b.x = -qb.x;
        conj_b.y = -qb.y;
        conj_b.z = -qb.z;
        conj_b.w = qb.w;
        r = hamilton(t, conj_b);
        r.w = 0;
      end
      res.x = r.x[DW-1:0];
      res.y = r.y[DW-1:0];
      res.z = r.z[DW-1:0];
      res.w = r.w[DW-1:0];
      return res;
    endfunction

    function void note_operands(logic op, quat_word_t a, quat_word_t b);
      expected_results.push_back(predict_result(op, a, b));
      if (op == OP_ROTATE) rotations++;
      else products++;
    endfunction

    function void check_result(quat_word_t got);
      quat_word_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat with nothing pending: x=%0d y=%0d z=%0d w=%0d",
                   $signed(got.x), $signed(got.y), $signed(got.z), $signed(got.w));
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (got.x !== want.x || got.y !== want.y || got.z !== want.z || got.w !== want.w) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result %0d wrong: expected x=%0d y=%0d z=%0d w=%0d, ",
                    "got x=%0d y=%0d z=%0d w=%0d"},
                   checked, $signed(want.x), $signed(want.y), $signed(want.z), $signed(want.w),
                   $signed(got.x), $signed(got.y), $signed(got.z), $signed(got.w));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_op = OP_PRODUCT;
  word_t in_a_x = '0;
  word_t in_a_y = '0;
  word_t in_a_z = '0;
  word_t in_a_w = '0;
  word_t in_b_x = '0;
  word_t in_b_y = '0;
  word_t in_b_z = '0;
  word_t in_b_w = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  word_t out_r_x;
  word_t out_r_y;
  word_t out_r_z;
  word_t out_r_w;

  quat_checker board;
  int in_gap_pct = 20;
  int out_stall_pct = 20;
  int stall_left = 0;
  bit quiet_tail = 1'b0;

  quaternion_product_rotate #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) uut (.*);

  always #10 clk = ~clk;

  // receiver back-pressure in bursts
  always @(posedge clk) begin
    if (!rst_n || quiet_tail) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(99) < out_stall_pct) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result('{out_r_x, out_r_y, out_r_z, out_r_w});
  end

  initial begin
    int stuck;
    stuck = 0;
    do begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end while (stuck < STUCK_LIMIT);
    $display("no beat moved for %0d cycles", STUCK_LIMIT);
    $display("quaternion_product_rotate verification failed");
    $finish;
  end

  task automatic pause_input();
    if (!quiet_tail && $urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // valid stays up until the beat is taken; pause_input lowers it only for a gap
  task automatic send_beat(input logic op, input quat_word_t a, input quat_word_t b);
    pause_input();
    in_valid <= 1'b1;
    in_op <= op;
    in_a_x <= a.x;
    in_a_y <= a.y;
    in_a_z <= a.z;
    in_a_w <= a.w;
    in_b_x <= b.x;
    in_b_y <= b.y;
    in_b_z <= b.z;
    in_b_w <= b.w;
    do @(posedge clk); while (in_stall);
    board.note_operands(op, a, b);
  endtask

  function automatic word_t random_component(int kind);
    case (kind)
      0: return word_t'($urandom);
      1: return word_t'(int'($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
      2: begin
        case ($urandom_range(0, 8))
          0: return word_t'(WORD_MIN);
          1: return word_t'(WORD_MIN + 1);
          2: return word_t'(-ONE_Q);
          3: return word_t'(-1);
          4: return '0;
          5: return word_t'(1);
          6: return word_t'(ONE_Q);
          7: return word_t'(WORD_MAX);
          default: return word_t'($urandom);
        endcase
      end
      default: return word_t'(int'($urandom_range(0, 128)) - 64);
    endcase
  endfunction

  function automatic quat_word_t random_operand(int kind);
    quat_word_t q;
    q.x = random_component(kind);
    q.y = random_component(kind);
    q.z = random_component(kind);
    q.w = random_component(kind);
    return q;
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 15;
      default: return 45;
    endcase
  endfunction

  initial begin
    logic op;
    int kind;
    board = new;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zeros, identity, extremes, rounding ties, known rotations
    send_beat(OP_PRODUCT, '{0, 0, 0, 0}, '{0, 0, 0, 0});
    send_beat(OP_ROTATE, '{0, 0, 0, 0}, '{0, 0, 0, 0});
    send_beat(OP_PRODUCT, '{1000, -2000, 3000, -4000}, '{0, 0, 0, ONE_Q});
    // quarter turn about z, scalar of the vector operand must be ignored
    send_beat(OP_ROTATE, '{ONE_Q, 0, 0, 32767}, '{0, 0, 11585, 11585});
    send_beat(OP_ROTATE, '{0, ONE_Q, 0, 0}, '{ONE_Q, 0, 0, 0});
    send_beat(OP_PRODUCT, '{32767, 32767, 32767, 32767}, '{32767, 32767, 32767, 32767});
    send_beat(OP_PRODUCT, '{-32768, -32768, -32768, -32768}, '{-32768, -32768, -32768, -32768});
    send_beat(OP_PRODUCT, '{32767, 32767, 32767, 32767}, '{-32768, -32768, -32768, -32768});
    send_beat(OP_ROTATE, '{32767, 32767, 32767, 32767}, '{32767, 32767, 32767, 32767});
    // conjugate of the most negative value must not saturate
    send_beat(OP_ROTATE, '{-32768, -32768, -32768, -32768}, '{-32768, -32768, -32768, -32768});
    send_beat(OP_ROTATE, '{-32768, 0, 0, 0}, '{-32768, 0, 0, 0});
    // half-lsb ties on both sides of zero
    send_beat(OP_PRODUCT, '{1, 0, 0, 0}, '{0, 0, 0, 8192});
    send_beat(OP_PRODUCT, '{-1, 0, 0, 0}, '{0, 0, 0, 8192});
    send_beat(OP_PRODUCT, '{0, 0, 3, 0}, '{0, 8192, 0, 0});
    send_beat(OP_PRODUCT, '{21845, -21846, 21845, -21846}, '{-21846, 21845, -21846, 21845});
    send_beat(OP_ROTATE, '{-21846, 21845, -21846, 21845}, '{21845, -21846, 21845, -21846});
    // unnormalized rotor drives the intermediate product into saturation
    send_beat(OP_ROTATE, '{ONE_Q, ONE_Q, ONE_Q, -32768}, '{ONE_Q, ONE_Q, ONE_Q, ONE_Q});
    send_beat(OP_ROTATE, '{-1, -1, -1, -1}, '{-1, -1, -1, -1});
    send_beat(OP_ROTATE, '{1, -1, 1, 0}, '{8192, 8192, 8192, 8192});

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i % 50 == 0) begin
        in_gap_pct = pick_idle_pct();
        out_stall_pct = pick_idle_pct();
      end
      if (i == RANDOM_BEATS - QUIET_BEATS) quiet_tail = 1'b1;
      op = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: kind = 0;
        8, 9, 10, 11, 12, 13: kind = 1;
        14, 15, 16: kind = 2;
        default: kind = 3;
      endcase
      send_beat(op, random_operand(kind), random_operand($urandom_range(0, 1) ? kind : 0));
    end
    in_valid <= 1'b0;

    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d product and %0d rotation beats, checked %0d results",
             board.products, board.rotations, board.checked);
    $display("%0d mismatches, %0d results still pending",
             board.mismatches, board.expected_results.size());
    if (board.mismatches == 0 && board.expected_results.size() == 0) begin
      $display("quaternion_product_rotate verification clean");
    end else begin
      $display("quaternion_product_rotate verification failed");
    end
    $finish;
  end

endmodule
